>>> rtl/lcdt_pkg.sv
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types and timing constants for the LCD mode and LY/LYC timing core.
// ----------------------------------------------------------------------------
package lcdt_pkg;

  localparam int unsigned CntW = 9;

  localparam logic [CntW-1:0] CLOCKS_PER_TICK = 9'd4;
  localparam logic [CntW-1:0] OAM_CLOCKS      = 9'd80;
  localparam logic [CntW-1:0] XFER_CLOCKS     = 9'd172;
  localparam logic [CntW-1:0] HBLANK_CLOCKS   = 9'd204;
  localparam logic [CntW-1:0] LINE_CLOCKS     = 9'd456;

  localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [7:0] LINES_PER_FRAME   = 8'd154;
  localparam logic [7:0] STAT_READ_SET     = 8'h80;
  localparam logic [7:0] UNMAPPED_READ     = 8'hFF;

  localparam logic [3:0] REG_STAT = 4'd1;
  localparam logic [3:0] REG_LY   = 4'd4;
  localparam logic [3:0] REG_LYC  = 4'd5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  // irq_en: [3] LYC, [2] OAM, [1] VBlank, [0] HBlank (STAT bits 6..3)
  typedef struct packed {
    logic [3:0] irq_en;
    logic       coinc;
    lcd_mode_t  mode;
  } stat_t;

  typedef struct packed {
    logic [CntW-1:0] countdown;
    stat_t           stat;
    logic [7:0]      ly;
    logic [7:0]      lyc;
  } lcdt_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_render_start;
    logic [7:0] render_line;
    lcd_mode_t  mode_now;
  } lcdt_result_t;

endpackage

>>> rtl/lcdt_step.sv
// ----------------------------------------------------------------------------
// lcdt_step
// Next-state and result logic for one item: tick, register write or read.
// ----------------------------------------------------------------------------
module lcdt_step
  import lcdt_pkg::*;
(
  input  lcdt_state_t  cur,
  input  logic [1:0]   cmd,
  input  logic [3:0]   reg_offset,
  input  logic [7:0]   write_data,
  output lcdt_state_t  nxt,
  output lcdt_result_t res
);

  always_comb begin
    logic       coinc_irq;
    logic       mode_irq;
    logic       vbl;
    logic       rend;
    logic [7:0] ly_inc;
    logic [7:0] ly_new;
    logic       refresh;
    lcd_mode_t  next_mode;
    logic [7:0] rd;

    nxt       = cur;
    coinc_irq = 1'b0;
    mode_irq  = 1'b0;
    vbl       = 1'b0;
    rend      = 1'b0;
    refresh   = 1'b0;
    rd        = 8'd0;
    ly_inc    = cur.ly + 8'd1;
    ly_new    = cur.ly;
    next_mode = cur.stat.mode;

    case (cmd_t'(cmd))
      CMD_TICK: begin
        if (cur.countdown > CLOCKS_PER_TICK) begin
          nxt.countdown = cur.countdown - CLOCKS_PER_TICK;
        end else begin
          unique case (cur.stat.mode)
            MODE_HBLANK: begin
              ly_new    = ly_inc;
              refresh   = 1'b1;
              next_mode = (ly_inc < FIRST_VBLANK_LINE) ? MODE_OAM : MODE_VBLANK;
            end
            MODE_VBLANK: begin
              refresh = 1'b1;
              if (ly_inc >= LINES_PER_FRAME) begin
                ly_new    = 8'd0;
                next_mode = MODE_OAM;
              end else begin
                ly_new    = ly_inc;
                next_mode = MODE_VBLANK;
              end
            end
            MODE_OAM:  next_mode = MODE_XFER;
            MODE_XFER: next_mode = MODE_HBLANK;
            default:   next_mode = MODE_HBLANK;
          endcase
          nxt.ly        = ly_new;
          nxt.stat.mode = next_mode;
          if (next_mode != cur.stat.mode) begin
            unique case (next_mode)
              MODE_HBLANK: mode_irq = cur.stat.irq_en[0];
              MODE_VBLANK: begin
                vbl      = 1'b1;
                mode_irq = cur.stat.irq_en[1] | cur.stat.irq_en[2];
              end
              MODE_OAM:  mode_irq = cur.stat.irq_en[2];
              MODE_XFER: rend = 1'b1;
              default:   mode_irq = 1'b0;
            endcase
          end
          unique case (next_mode)
            MODE_HBLANK: nxt.countdown = HBLANK_CLOCKS;
            MODE_VBLANK: nxt.countdown = LINE_CLOCKS;
            MODE_OAM:    nxt.countdown = OAM_CLOCKS;
            MODE_XFER:   nxt.countdown = XFER_CLOCKS;
            default:     nxt.countdown = LINE_CLOCKS;
          endcase
        end
      end
      CMD_WRITE: begin
        if (reg_offset == REG_STAT) begin
          nxt.stat.irq_en = write_data[6:3];
          nxt.stat.coinc  = write_data[2];
        end else if (reg_offset == REG_LY) begin
          nxt.ly  = write_data;
          refresh = 1'b1;
        end else if (reg_offset == REG_LYC) begin
          nxt.lyc = write_data;
          refresh = 1'b1;
        end
      end
      CMD_READ: begin
        if (reg_offset == REG_STAT) begin
          rd = STAT_READ_SET | {1'b0, cur.stat};
        end else if (reg_offset == REG_LY) begin
          rd = cur.ly;
        end else if (reg_offset == REG_LYC) begin
          rd = cur.lyc;
        end else begin
          rd = UNMAPPED_READ;
        end
      end
      default: rd = 8'd0;
    endcase

    if (refresh) begin
      nxt.stat.coinc = (nxt.ly == nxt.lyc);
      coinc_irq      = (nxt.ly == nxt.lyc) & cur.stat.irq_en[3];
    end

    res.read_data         = rd;
    res.vblank_irq        = vbl;
    res.stat_irq          = coinc_irq | mode_irq;
    res.line_render_start = rend;
    res.render_line       = nxt.ly;
    res.mode_now          = nxt.stat.mode;
  end

endmodule

>>> rtl/lcdt_obuf.sv
// ----------------------------------------------------------------------------
// lcdt_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module lcdt_obuf
  import lcdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lcdt_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output lcdt_result_t out_data
);

  logic         skid_valid;
  lcdt_result_t skid_data;
  logic         take;

  assign take = out_valid & ~out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_data;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/lcd_mode_timing_and_lyc_core.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_and_lyc_core
// LCD mode/line timing with STAT, LY and LYC registers and interrupt pulses.
// ----------------------------------------------------------------------------
// One item (machine-cycle tick, register write or register read) is taken per
// clock while in_stall is low. The timing state is updated in a single
// combinational pass at the accepting edge; the result is registered at that
// edge into the output register, or the skid register if that one is stalled.
// A two-entry output buffer lets items keep flowing while a result waits;
// in_stall rises only when both entries hold results not yet taken.
// ----------------------------------------------------------------------------
module lcd_mode_timing_and_lyc_core
  import lcdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       vblank_irq,
  output logic       stat_irq,
  output logic       line_render_start,
  output logic [7:0] render_line,
  output logic [1:0] mode_now
);

  lcdt_state_t  state;
  lcdt_state_t  state_next;
  lcdt_result_t step_res;
  lcdt_result_t res;
  logic         accept;
  logic         buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  lcdt_step u_step (
    .cur        (state),
    .cmd        (cmd),
    .reg_offset (reg_offset),
    .write_data (write_data),
    .nxt        (state_next),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.countdown <= LINE_CLOCKS;
      state.stat      <= '{irq_en: 4'd0, coinc: 1'b0, mode: MODE_HBLANK};
      state.ly        <= 8'd0;
      state.lyc       <= 8'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  lcdt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res)
  );

  assign read_data         = res.read_data;
  assign vblank_irq        = res.vblank_irq;
  assign stat_irq          = res.stat_irq;
  assign line_render_start = res.line_render_start;
  assign render_line       = res.render_line;
  assign mode_now          = res.mode_now;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state.countdown != '0 && state.countdown <= LINE_CLOCKS)
    else $error("mode countdown out of range");

  a_render_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_render_start |-> mode_now == MODE_XFER)
    else $error("render start outside transfer mode");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> mode_now == MODE_VBLANK)
    else $error("vblank irq outside vblank mode");

  a_full_has_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry held without output entry");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> $stable(state))
    else $error("state changed without an accepted item");

endmodule
